// ===== sv/vzs_pkg.sv =====
// Shared types and constants for the varint / ZigZag value serializer.
package vzs_pkg;

	localparam logic [2:0] CMD_BYTE     = 3'd0;
	localparam logic [2:0] CMD_INT16    = 3'd1;
	localparam logic [2:0] CMD_INT32    = 3'd2;
	localparam logic [2:0] CMD_VARINT32 = 3'd3;
	localparam logic [2:0] CMD_VARINT64 = 3'd4;
	localparam logic [2:0] CMD_ZIGZAG32 = 3'd5;
	localparam logic [2:0] CMD_ZIGZAG64 = 3'd6;
	localparam logic [2:0] CMD_CLEAR    = 3'd7;

	localparam logic [1:0] ORD_DEFAULT = 2'd0;
	localparam logic [1:0] ORD_BIG     = 2'd1;
	localparam logic [1:0] ORD_LITTLE  = 2'd2;

	localparam logic [7:0] CONT_BIT   = 8'h80;
	localparam int         GROUP_BITS = 7;

	typedef struct packed {
		logic load;
		logic clear;
		logic step;
	} vzs_ctl_t;

	typedef struct packed {
		logic slot_free;
		logic last;
	} vzs_stat_t;

endpackage

// ===== sv/vzs_ctrl.sv =====
// Controller state machine for the value serializer.
module vzs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [2:0]       cmd,
	input  vzs_pkg::vzs_stat_t stat,
	output logic             in_stall,
	output vzs_pkg::vzs_ctl_t  ctl
);
	import vzs_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t state_q;

	always_comb begin
		ctl       = '0;
		in_stall  = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				ctl.load  = in_valid && (cmd != CMD_CLEAR);
				ctl.clear = in_valid && (cmd == CMD_CLEAR);
			end
			ST_EMIT: begin
				ctl.step = stat.slot_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.load) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (ctl.step && stat.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/vzs_dp.sv =====
// Datapath for the value serializer: byte shifter, offset counter, output register.
module vzs_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  vzs_pkg::vzs_ctl_t ctl,
	output vzs_pkg::vzs_stat_t stat,
	input  logic [2:0]        cmd,
	input  logic [63:0]       payload,
	input  logic [1:0]        order_request,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic              cfg_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic [31:0]       byte_offset,
	output logic              last_of_item
);
	import vzs_pkg::*;

	logic        dflt_order_q;
	logic [63:0] val_q;
	logic        is_var_q;
	logic [1:0]  cnt_q;
	logic [31:0] offset_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [31:0] byte_offset_q;
	logic        last_q;

	logic        little;
	logic [63:0] load_val;
	logic        load_var;
	logic [1:0]  load_cnt;
	logic [15:0] v16;
	logic [31:0] v32;
	logic [31:0] zz32;
	logic [63:0] zz64;
	logic        cur_last;
	logic [7:0]  cur_byte;

	always_comb begin
		priority if (order_request == ORD_BIG) begin
			little = 1'b0;
		end else if (order_request == ORD_LITTLE) begin
			little = 1'b1;
		end else begin
			little = dflt_order_q;
		end
	end

	assign v16  = little ? payload[15:0] : {payload[7:0], payload[15:8]};
	assign v32  = little ? payload[31:0]
		: {payload[7:0], payload[15:8], payload[23:16], payload[31:24]};
	assign zz32 = {payload[30:0], 1'b0} ^ {32{payload[31]}};
	assign zz64 = {payload[62:0], 1'b0} ^ {64{payload[63]}};

	always_comb begin
		load_val = 64'd0;
		load_var = 1'b0;
		load_cnt = 2'd0;
		unique case (cmd)
			CMD_BYTE: begin
				load_val = {56'd0, payload[7:0]};
			end
			CMD_INT16: begin
				load_val = {48'd0, v16};
				load_cnt = 2'd1;
			end
			CMD_INT32: begin
				load_val = {32'd0, v32};
				load_cnt = 2'd3;
			end
			CMD_VARINT32: begin
				load_val = {32'd0, payload[31:0]};
				load_var = 1'b1;
			end
			CMD_VARINT64: begin
				load_val = payload;
				load_var = 1'b1;
			end
			CMD_ZIGZAG32: begin
				load_val = {32'd0, zz32};
				load_var = 1'b1;
			end
			CMD_ZIGZAG64: begin
				load_val = zz64;
				load_var = 1'b1;
			end
			default: begin
				load_val = 64'd0;
			end
		endcase
	end

	assign cur_last = is_var_q ? (val_q[63:GROUP_BITS] == '0) : (cnt_q == 2'd0);
	assign cur_byte = (is_var_q && !cur_last) ? (val_q[7:0] | CONT_BIT) : val_q[7:0];

	assign stat.slot_free = !out_valid_q || !out_stall;
	assign stat.last      = cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_order_q <= 1'b0;
			offset_q     <= 32'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dflt_order_q <= cfg_data;
			end
			if (ctl.clear) begin
				offset_q <= 32'd0;
			end else if (ctl.step) begin
				offset_q <= offset_q + 32'd1;
			end
			if (ctl.step) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			val_q    <= load_val;
			is_var_q <= load_var;
			cnt_q    <= load_cnt;
		end else if (ctl.step) begin
			val_q <= is_var_q ? (val_q >> GROUP_BITS) : (val_q >> 8);
			cnt_q <= cnt_q - 2'd1;
		end
		if (ctl.step) begin
			out_byte_q    <= cur_byte;
			byte_offset_q <= offset_q;
			last_q        <= cur_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign byte_offset  = byte_offset_q;
	assign last_of_item = last_q;

endmodule

// ===== sv/varint_zigzag_value_serializer.sv =====
// Varint / ZigZag / fixed-width value serializer, top level.
// Input channel (in_valid, in_stall): one item per transfer, carrying cmd,
// payload and order_request. Output channel (out_valid, out_stall): one
// serialized byte per transfer with its stream offset and a last-byte mark.
// Configuration channel (cfg_valid, cfg_ready, cfg_data): writes the default
// byte order; cfg_ready is always high, so every write is accepted.
// An item yields N output bytes (1 to 10), the output register emitting one
// byte per cycle while the receiver does not stall; the first byte enters the
// output register from the emit state that follows the input transfer. A clear
// item resets the stream offset and emits nothing.
// The next item is accepted while the last byte of the previous one still
// sits in the output register.
// A stall from the receiver holds the output register and pauses the byte
// shifter; nothing is lost or repeated.
// Reset clears the stream offset, the default byte order (big endian) and
// the output valid; the block is ready for an item right after reset.
module varint_zigzag_value_serializer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [63:0] payload,
	input  logic [1:0]  order_request,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [31:0] byte_offset,
	output logic        last_of_item
);
	import vzs_pkg::*;

	vzs_ctl_t  ctl;
	vzs_stat_t stat;

	assign cfg_ready = 1'b1;

	vzs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.stat     (stat),
		.in_stall (in_stall),
		.ctl      (ctl)
	);

	vzs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.cmd           (cmd),
		.payload       (payload),
		.order_request (order_request),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.byte_offset   (byte_offset),
		.last_of_item  (last_of_item)
	);

`ifndef ASSERT_OFF
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> in_stall)
		else $error("item load did not make the block busy");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step && !stat.last) |=> in_stall)
		else $error("block went idle before the last byte");

	a_step_out: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |=> out_valid)
		else $error("emitted byte missing from output register");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.step && (ctl.load || ctl.clear)))
		else $error("byte step overlaps an item transfer");
`endif

endmodule
